// ===== hdl/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rail power conversion package
// Shared constants, rail codes and the divider step used by the
// conversion pipeline.
// ----------------------------------------------------------------------------
package rpc_pkg;

	localparam int unsigned NUM_PORTS = 16;
	localparam logic [31:0] MAP_RESET = 32'h0490_0223;

	typedef enum logic [1:0] {
		RAIL_12V = 2'd0,
		RAIL_5V  = 2'd1,
		RAIL_3V3 = 2'd2,
		RAIL_REF = 2'd3
	} rail_t;

	localparam int unsigned REF_BIAS = 1024;
	localparam int unsigned AMP_GAIN = 3125;

	localparam int unsigned RECIP_9   = 233017;
	localparam int unsigned SHIFT_9   = 21;
	localparam int unsigned RECIP_133 = 8073247;
	localparam int unsigned SHIFT_133 = 30;
	localparam int unsigned RECIP_83  = 3234163;
	localparam int unsigned SHIFT_83  = 28;
	localparam int unsigned RECIP_5   = 26215;
	localparam int unsigned SHIFT_5   = 17;
	localparam int unsigned RECIP_125 = 274877907;
	localparam int unsigned SHIFT_125 = 35;

	localparam int unsigned DIV_A = 8;
	localparam int unsigned DIV_B = 8;
	localparam int unsigned DIV_C = 7;
	localparam int unsigned DIV_Q = DIV_A + DIV_B + DIV_C;

	// One restoring step: returns the quotient bit over the new remainder.
	function automatic logic [10:0] div_step(input logic [9:0] rem, input logic [9:0] dvs,
		input logic din);
		logic [10:0] t;
		logic [10:0] r;
		t = {rem, din};
		if (t >= {1'b0, dvs}) begin
			r = {1'b1, 10'(t - {1'b0, dvs})};
		end else begin
			r = {1'b0, t[9:0]};
		end
		return r;
	endfunction

endpackage

// ===== hdl/rail_power_conversion_unit.sv =====
// ----------------------------------------------------------------------------
// Rail power conversion unit
// Converts a port number, a current sample and a voltage sample into
// milliamps, millivolts and milliwatts, with a per-port rail map.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while the result side does not
// stall; a stall on the result side freezes the whole eight-stage pipeline
// and is passed back as sample_stall. The pipeline depth is set by the
// reciprocal divider of reference mode, which resolves 23 quotient bits
// over three stages, and by the power path, which multiplies, saturates
// and scales by 1/1000 over four more stages. The rail map is written
// through cfg_wr_en and cfg_wr_data and should only change while no
// request is in flight.
module rail_power_conversion_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [3:0]         port,
	input  logic [9:0]         current_sample,
	input  logic [15:0]        voltage_sample,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [23:0] milliamps,
	output logic [22:0]        millivolts,
	output logic signed [22:0] milliwatts,
	output logic               divide_by_zero
);

	logic [31:0] map_q;
	logic        adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	rpc_pkg::rail_t code_in, code_s1, code_s2, code_s3, code_s4;
	logic        dz_in, dz_s1, dz_s2, dz_s3, dz_s4, dz_s5, dz_s6, dz_s7, dz_s8;
	logic [13:0] ten_in, mag_in;
	logic        ineg_in, ineg_s1, ineg_s2;
	logic [24:0] nm_in;
	logic [25:0] v535_in;
	logic [22:0] v69_in;
	logic [19:0] v11_in;
	logic [21:0] yv_in, yv_s1;
	logic [17:0] yi_s1;
	logic [9:0]  a_s1, a_s2, a_s3;
	logic [9:0]  vl_s1, vl_s2, vl_s3;

	logic [22:0] mulv;
	logic [44:0] pv_s2;
	logic [35:0] pi_s2;
	logic [10:0] st_a1, st_v1, st_a2, st_v2, st_a3, st_v3;
	logic [9:0]  ra1, rv1, ra2, rv2, ra3, rv3;
	logic [9:0]  ra_s2, rv_s2, ra_s3, rv_s3;
	logic [rpc_pkg::DIV_A-1:0] qa1, qv1, qa_s2, qv_s2;
	logic [rpc_pkg::DIV_A+rpc_pkg::DIV_B-1:0] qa2, qv2, qa_s3, qv_s3;
	logic [rpc_pkg::DIV_Q-1:0] qa3, qv3;

	logic [14:0] mi;
	logic [23:0] man, man_s3, ma_sel;
	logic [22:0] mvn, mvn_s3, mv_sel;
	logic [23:0] ma_s4, ma_s5, ma_s6, ma_s7, ma_s8;
	logic [22:0] mv_s4, mv_s5, mv_s6, mv_s7, mv_s8;

	logic signed [47:0] prod_s5;
	logic [31:0] pmag;
	logic        pneg, pneg_s6, pneg_s7;
	logic [28:0] y_s6;
	logic [57:0] p_s7;
	logic [22:0] qw, mw_s8;

	assign adv          = !(vld_s8 && result_stall);
	assign sample_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= rpc_pkg::MAP_RESET;
		end else if (cfg_wr_en) begin
			map_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_comb begin
		if ({1'b0, port} < 5'(rpc_pkg::NUM_PORTS)) begin
			code_in = rpc_pkg::rail_t'(map_q[{port, 1'b0} +: 2]);
		end else begin
			code_in = rpc_pkg::RAIL_REF;
		end
		dz_in   = (code_in == rpc_pkg::RAIL_REF) &&
			((current_sample == 10'd0) || (voltage_sample[9:0] == 10'd0));
		ten_in  = 14'({current_sample, 3'b000}) + 14'({current_sample, 1'b0});
		ineg_in = ten_in < 14'(rpc_pkg::REF_BIAS);
		mag_in  = ineg_in ? (14'(rpc_pkg::REF_BIAS) - ten_in) : (ten_in - 14'(rpc_pkg::REF_BIAS));
		nm_in   = 25'(mag_in) * 25'(rpc_pkg::AMP_GAIN);
		v535_in = 26'(voltage_sample) * 26'd535;
		v69_in  = 23'(voltage_sample) * 23'd69;
		v11_in  = 20'(voltage_sample) * 20'd11;
		case (code_in)
			rpc_pkg::RAIL_12V: yv_in = v535_in[25:4];
			rpc_pkg::RAIL_5V:  yv_in = 22'(v69_in[22:3]);
			rpc_pkg::RAIL_3V3: yv_in = 22'(v11_in[19:5]);
			default:           yv_in = '0;
		endcase
	end

	always_comb begin
		case (code_s1)
			rpc_pkg::RAIL_12V: mulv = 23'(rpc_pkg::RECIP_133);
			rpc_pkg::RAIL_5V:  mulv = 23'(rpc_pkg::RECIP_83);
			rpc_pkg::RAIL_3V3: mulv = 23'(rpc_pkg::RECIP_5);
			default:           mulv = '0;
		endcase
		ra1 = '0;
		rv1 = '0;
		qa1 = '0;
		qv1 = '0;
		for (int i = 0; i < rpc_pkg::DIV_A; i++) begin
			st_a1 = rpc_pkg::div_step(ra1, a_s1, (i == 0));
			st_v1 = rpc_pkg::div_step(rv1, vl_s1, (i == 0));
			ra1   = st_a1[9:0];
			rv1   = st_v1[9:0];
			qa1   = {qa1[rpc_pkg::DIV_A-2:0], st_a1[10]};
			qv1   = {qv1[rpc_pkg::DIV_A-2:0], st_v1[10]};
		end
	end

	always_comb begin
		mi  = 15'(pi_s2 >> rpc_pkg::SHIFT_9);
		man = ineg_s2 ? (24'd0 - 24'(mi)) : 24'(mi);
		case (code_s2)
			rpc_pkg::RAIL_12V: mvn = 23'(pv_s2 >> rpc_pkg::SHIFT_133);
			rpc_pkg::RAIL_5V:  mvn = 23'(pv_s2 >> rpc_pkg::SHIFT_83);
			rpc_pkg::RAIL_3V3: mvn = 23'(pv_s2 >> rpc_pkg::SHIFT_5);
			default:           mvn = '0;
		endcase
		ra2 = ra_s2;
		rv2 = rv_s2;
		qa2 = {qa_s2, {rpc_pkg::DIV_B{1'b0}}};
		qv2 = {qv_s2, {rpc_pkg::DIV_B{1'b0}}};
		for (int i = 0; i < rpc_pkg::DIV_B; i++) begin
			st_a2 = rpc_pkg::div_step(ra2, a_s2, 1'b0);
			st_v2 = rpc_pkg::div_step(rv2, vl_s2, 1'b0);
			ra2   = st_a2[9:0];
			rv2   = st_v2[9:0];
			qa2[rpc_pkg::DIV_B-1-i] = st_a2[10];
			qv2[rpc_pkg::DIV_B-1-i] = st_v2[10];
		end
	end

	always_comb begin
		ra3 = ra_s3;
		rv3 = rv_s3;
		qa3 = {qa_s3, {rpc_pkg::DIV_C{1'b0}}};
		qv3 = {qv_s3, {rpc_pkg::DIV_C{1'b0}}};
		for (int i = 0; i < rpc_pkg::DIV_C; i++) begin
			st_a3 = rpc_pkg::div_step(ra3, a_s3, 1'b0);
			st_v3 = rpc_pkg::div_step(rv3, vl_s3, 1'b0);
			ra3   = st_a3[9:0];
			rv3   = st_v3[9:0];
			qa3[rpc_pkg::DIV_C-1-i] = st_a3[10];
			qv3[rpc_pkg::DIV_C-1-i] = st_v3[10];
		end
		if (dz_s3) begin
			ma_sel = '0;
			mv_sel = '0;
		end else if (code_s3 == rpc_pkg::RAIL_REF) begin
			ma_sel = 24'(qa3);
			mv_sel = qv3;
		end else begin
			ma_sel = man_s3;
			mv_sel = mvn_s3;
		end
	end

	always_comb begin
		if (prod_s5 > 48'sd2147483647) begin
			pneg = 1'b0;
			pmag = 32'h7FFF_FFFF;
		end else if (prod_s5 < -48'sd2147483648) begin
			pneg = 1'b1;
			pmag = 32'h8000_0000;
		end else begin
			pneg = prod_s5[47];
			pmag = pneg ? 32'(-prod_s5) : prod_s5[31:0];
		end
		qw = 23'(p_s7 >> rpc_pkg::SHIFT_125);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_s1 <= code_in;
			dz_s1   <= dz_in;
			ineg_s1 <= ineg_in;
			yi_s1   <= nm_in[24:7];
			yv_s1   <= yv_in;
			a_s1    <= current_sample;
			vl_s1   <= voltage_sample[9:0];

			code_s2 <= code_s1;
			dz_s2   <= dz_s1;
			ineg_s2 <= ineg_s1;
			pi_s2   <= 36'(yi_s1) * 36'(rpc_pkg::RECIP_9);
			pv_s2   <= 45'(yv_s1) * 45'(mulv);
			a_s2    <= a_s1;
			vl_s2   <= vl_s1;
			ra_s2   <= ra1;
			rv_s2   <= rv1;
			qa_s2   <= qa1;
			qv_s2   <= qv1;

			code_s3 <= code_s2;
			dz_s3   <= dz_s2;
			man_s3  <= man;
			mvn_s3  <= mvn;
			a_s3    <= a_s2;
			vl_s3   <= vl_s2;
			ra_s3   <= ra2;
			rv_s3   <= rv2;
			qa_s3   <= qa2;
			qv_s3   <= qv2;

			code_s4 <= code_s3;
			dz_s4   <= dz_s3;
			ma_s4   <= ma_sel;
			mv_s4   <= mv_sel;

			dz_s5   <= dz_s4;
			ma_s5   <= ma_s4;
			mv_s5   <= mv_s4;
			prod_s5 <= $signed(ma_s4) * $signed({1'b0, mv_s4});

			dz_s6   <= dz_s5;
			ma_s6   <= ma_s5;
			mv_s6   <= mv_s5;
			pneg_s6 <= pneg;
			y_s6    <= pmag[31:3];

			dz_s7   <= dz_s6;
			ma_s7   <= ma_s6;
			mv_s7   <= mv_s6;
			pneg_s7 <= pneg_s6;
			p_s7    <= 58'(y_s6) * 58'(rpc_pkg::RECIP_125);

			dz_s8   <= dz_s7;
			ma_s8   <= ma_s7;
			mv_s8   <= mv_s7;
			mw_s8   <= pneg_s7 ? (23'd0 - qw) : qw;
		end
	end

	assign result_valid   = vld_s8;
	assign milliamps      = $signed(ma_s8);
	assign millivolts     = mv_s8;
	assign milliwatts     = $signed(mw_s8);
	assign divide_by_zero = dz_s8;

`ifndef ASSERT_OFF
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && divide_by_zero |->
			milliamps == 24'sd0 && millivolts == 23'd0 && milliwatts == 23'sd0)
		else $error("divide_by_zero result carries nonzero values");

	a_dz_ref: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && dz_s4 |-> code_s4 == rpc_pkg::RAIL_REF)
		else $error("divide_by_zero raised outside reference mode");

	a_ref_pos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && code_s4 == rpc_pkg::RAIL_REF && !dz_s4 |->
			!ma_s4[23] && ma_s4 != 24'd0 && mv_s4 != 23'd0)
		else $error("reference mode reciprocal came out zero");

	a_mw_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && milliwatts != 23'sd0 |-> milliwatts[22] == milliamps[23])
		else $error("power sign disagrees with current sign");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> vld_s1)
		else $error("accepted request lost at pipeline entry");
`endif

endmodule
